@@ hdl/rle_sprite_line_decoder_defines.svh @@
// assertion macros used by the decode module of the sprite line decoder
// depends on nothing; included by files that carry concurrent checks
`ifndef RLE_SPRITE_LINE_DECODER_DEFINES_SVH
`define RLE_SPRITE_LINE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite line decoder check failed");

// next-cycle implication, disabled during reset
`define RSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite line decoder check failed");

`endif

@@ hdl/rsld_pkg.sv @@
// types, constants and helper functions of the sprite line decoder
// depends on nothing; imported by every decoder module
`timescale 1ns / 1ps

package rsld_pkg;

    // column counter width
    localparam int COLUMN_BITS = 12;

    // header byte class masks and codes
    localparam logic [7:0] HDR_MASK3    = 8'hE0;
    localparam logic [7:0] HDR_SEMI     = 8'h20;
    localparam logic [7:0] HDR_BLEND    = 8'h00;
    localparam logic [7:0] HDR_MASK2    = 8'hC0;
    localparam logic [7:0] HDR_LITERAL  = 8'h40;
    localparam logic [7:0] HDR_REPEAT   = 8'h80;
    localparam logic [7:0] HDR_END      = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // decoder phase
    typedef enum logic [2:0] {
        PH_HEADER       = 3'd0,
        PH_SEMI_INDEX   = 3'd1,
        PH_BLEND_ALPHA  = 3'd2,
        PH_BLEND_INDEX  = 3'd3,
        PH_LITERAL      = 3'd4,
        PH_REPEAT_INDEX = 3'd5
    } rsld_phase_t;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_start;
    } rsld_beat_t;

    // one output run
    typedef struct packed {
        logic [7:0]             alpha;
        logic [7:0]             color_index;
        logic                   transparent;
        logic [COLUMN_BITS-1:0] run_length;
        logic                   line_end;
    } rsld_run_t;

    // decoder result toward the output register
    typedef struct packed {
        logic      valid;
        rsld_run_t run;
    } rsld_result_t;

    // blend alpha byte a scaled as a*255/31, saturated at 255
    function automatic logic [7:0] blend_alpha(input logic [7:0] a);
        logic [7:0] q;
        if (a[7:5] != 3'd0)
        begin
            q = ALPHA_OPAQUE;
        end
        else
        begin
            case (a[4:0])
                5'd0:  q = 8'd0;
                5'd1:  q = 8'd8;
                5'd2:  q = 8'd16;
                5'd3:  q = 8'd24;
                5'd4:  q = 8'd32;
                5'd5:  q = 8'd41;
                5'd6:  q = 8'd49;
                5'd7:  q = 8'd57;
                5'd8:  q = 8'd65;
                5'd9:  q = 8'd74;
                5'd10: q = 8'd82;
                5'd11: q = 8'd90;
                5'd12: q = 8'd98;
                5'd13: q = 8'd106;
                5'd14: q = 8'd115;
                5'd15: q = 8'd123;
                5'd16: q = 8'd131;
                5'd17: q = 8'd139;
                5'd18: q = 8'd148;
                5'd19: q = 8'd156;
                5'd20: q = 8'd164;
                5'd21: q = 8'd172;
                5'd22: q = 8'd180;
                5'd23: q = 8'd189;
                5'd24: q = 8'd197;
                5'd25: q = 8'd205;
                5'd26: q = 8'd213;
                5'd27: q = 8'd222;
                5'd28: q = 8'd230;
                5'd29: q = 8'd238;
                5'd30: q = 8'd246;
                default: q = ALPHA_OPAQUE;
            endcase
        end
        return q;
    endfunction

    // single-pixel alpha a*255/32 from a 5-bit field
    function automatic logic [7:0] semi_alpha(input logic [4:0] a);
        logic [12:0] p;
        p = ({8'd0, a} << 8) - {8'd0, a};
        return p[12:5];
    endfunction

endpackage

@@ hdl/rsld_in_stage.sv @@
// input register of the sprite line decoder: holds one accepted beat
// depends on rsld_pkg
`timescale 1ns / 1ps

module rsld_in_stage import rsld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  rsld_beat_t in_beat,
    input  logic       advance,
    output logic       beat_valid,
    output rsld_beat_t beat
);

    logic       valid_reg;
    logic       valid_next;
    rsld_beat_t beat_reg;
    logic       load;

    // take a new beat whenever the held one moves on or none is held
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= in_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

@@ hdl/rsld_decode.sv @@
// line decoder state and per-byte decode with run clipping
// depends on rsld_pkg and rle_sprite_line_decoder_defines.svh
`timescale 1ns / 1ps

`include "rle_sprite_line_decoder_defines.svh"

module rsld_decode import rsld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [COLUMN_BITS-1:0] cfg_width,
    input  logic                   fire,
    input  rsld_beat_t             beat,
    output rsld_result_t           result
);

    rsld_phase_t            phase_reg, phase_next;
    logic [5:0]             run_count_reg, run_count_next;
    logic [7:0]             held_alpha_reg, held_alpha_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic                   line_done_reg, line_done_next;
    logic [COLUMN_BITS-1:0] line_width_reg;

    // run request from the byte decode
    logic                   req;
    logic [7:0]             req_alpha;
    logic [7:0]             req_index;
    logic                   req_transp;
    logic [COLUMN_BITS-1:0] req_count;
    logic                   done_dec;

    logic [COLUMN_BITS-1:0] width_eff;
    logic [COLUMN_BITS-1:0] col_in;
    logic [COLUMN_BITS-1:0] remain;
    logic [COLUMN_BITS-1:0] len;
    logic [7:0]             b;

    assign b         = beat.data_byte;
    assign width_eff = (line_width_reg == '0) ? COLUMN_BITS'(1) : line_width_reg;

    // byte decode against the phase, after a line start clear
    always_comb
    begin
        phase_next      = phase_reg;
        run_count_next  = run_count_reg;
        held_alpha_next = held_alpha_reg;
        col_in          = column_reg;
        done_dec        = line_done_reg;
        req             = 1'b0;
        req_alpha       = 8'd0;
        req_index       = 8'd0;
        req_transp      = 1'b0;
        req_count       = '0;

        if (beat.line_start)
        begin
            phase_next      = PH_HEADER;
            run_count_next  = 6'd0;
            held_alpha_next = 8'd0;
            col_in          = '0;
            done_dec        = 1'b0;
        end

        if (!done_dec)
        begin
            case (phase_next)
                PH_HEADER:
                begin
                    if (b == HDR_END)
                    begin
                        req        = 1'b1;
                        req_transp = 1'b1;
                        req_count  = '1;
                        done_dec   = 1'b1;
                    end
                    else if ((b & HDR_MASK3) == HDR_SEMI)
                    begin
                        held_alpha_next = semi_alpha(b[4:0]);
                        phase_next      = PH_SEMI_INDEX;
                    end
                    else if ((b & HDR_MASK3) == HDR_BLEND)
                    begin
                        run_count_next = {1'b0, b[4:0]};
                        phase_next     = PH_BLEND_ALPHA;
                    end
                    else if ((b & HDR_MASK2) == HDR_LITERAL)
                    begin
                        run_count_next = b[5:0];
                        phase_next     = (b[5:0] != 6'd0) ? PH_LITERAL : PH_HEADER;
                    end
                    else if ((b & HDR_MASK2) == HDR_REPEAT)
                    begin
                        run_count_next = b[5:0];
                        phase_next     = PH_REPEAT_INDEX;
                    end
                    else
                    begin
                        req        = 1'b1;
                        req_transp = 1'b1;
                        req_count  = COLUMN_BITS'(b[5:0]);
                    end
                end
                PH_SEMI_INDEX:
                begin
                    req        = 1'b1;
                    req_alpha  = held_alpha_next;
                    req_index  = b;
                    req_count  = COLUMN_BITS'(1);
                    phase_next = PH_HEADER;
                end
                PH_BLEND_ALPHA:
                begin
                    held_alpha_next = blend_alpha(b);
                    phase_next      = PH_BLEND_INDEX;
                end
                PH_BLEND_INDEX:
                begin
                    req            = 1'b1;
                    req_alpha      = held_alpha_next;
                    req_index      = b;
                    req_count      = COLUMN_BITS'(run_count_next);
                    run_count_next = 6'd0;
                    phase_next     = PH_HEADER;
                end
                PH_LITERAL:
                begin
                    req            = 1'b1;
                    req_alpha      = ALPHA_OPAQUE;
                    req_index      = b;
                    req_count      = COLUMN_BITS'(1);
                    run_count_next = run_count_next - 6'd1;
                    if (run_count_next == 6'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_REPEAT_INDEX:
                begin
                    req            = 1'b1;
                    req_alpha      = ALPHA_OPAQUE;
                    req_index      = b;
                    req_count      = COLUMN_BITS'(run_count_next);
                    run_count_next = 6'd0;
                    phase_next     = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // clip the requested run to the line width
    always_comb
    begin
        column_next    = col_in;
        line_done_next = done_dec;
        remain         = width_eff - col_in;
        len            = (req_count < remain) ? req_count : remain;
        result         = '0;
        if (req && (req_count != '0))
        begin
            if (col_in >= width_eff)
            begin
                line_done_next = 1'b1;
            end
            else
            begin
                column_next                = col_in + len;
                result.valid               = 1'b1;
                result.run.alpha           = req_alpha;
                result.run.color_index     = req_index;
                result.run.transparent     = req_transp;
                result.run.run_length      = len;
                result.run.line_end        = (len == remain);
                if (len == remain)
                begin
                    line_done_next = 1'b1;
                end
            end
        end
    end

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= COLUMN_BITS'(1);
        end
        else if (cfg_write)
        begin
            line_width_reg <= cfg_width;
        end
    end

    // decoder state, updated once per decoded beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            run_count_reg  <= 6'd0;
            held_alpha_reg <= 8'd0;
            column_reg     <= '0;
            line_done_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            run_count_reg  <= run_count_next;
            held_alpha_reg <= held_alpha_next;
            column_reg     <= column_next;
            line_done_reg  <= line_done_next;
        end
    end

    // checks
    `RSLD_ASSERT_NEXT(a_end_closes_line, clk, rst_n,
        fire && result.valid && result.run.line_end, line_done_reg)
    `RSLD_ASSERT_IMPL(a_literal_count, clk, rst_n,
        phase_reg == PH_LITERAL, run_count_reg != 6'd0)
    `RSLD_ASSERT_NEXT(a_done_holds_column, clk, rst_n,
        line_done_reg && !(fire && beat.line_start), $stable(column_reg))
    `RSLD_ASSERT_IMPL(a_run_nonzero, clk, rst_n,
        result.valid, result.run.run_length != '0)

endmodule

@@ hdl/rsld_out_stage.sv @@
// output register of the sprite line decoder: holds one run until taken
// depends on rsld_pkg
`timescale 1ns / 1ps

module rsld_out_stage import rsld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         beat_valid,
    input  rsld_result_t result,
    output logic         advance,
    output logic         out_valid,
    input  logic         out_stall,
    output rsld_run_t    out_run
);

    logic      valid_reg;
    logic      valid_next;
    rsld_run_t run_reg;
    logic      room;

    // a beat may move on when the register is empty or being drained
    assign room    = !valid_reg || !out_stall;
    assign advance = beat_valid && room;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = advance && result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            run_reg <= result.run;
        end
    end

    assign out_valid = valid_reg;
    assign out_run   = run_reg;

endmodule

@@ hdl/rle_sprite_line_decoder.sv @@
// an accepted byte is decoded from the input register into the run register
// throughput: one byte per cycle; set by the single decode step between the
// input register and the run register, output stalls hold the input register
// reset: width 1, header phase, column 0, both registers empty
// top level of the sprite line decoder; depends on rsld_pkg, rsld_in_stage,
// rsld_decode and rsld_out_stage
`timescale 1ns / 1ps

module rle_sprite_line_decoder import rsld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [COLUMN_BITS-1:0] line_width,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   line_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             alpha,
    output logic [7:0]             color_index,
    output logic                   transparent,
    output logic [COLUMN_BITS-1:0] run_length,
    output logic                   line_end
);

    rsld_beat_t   in_beat;
    rsld_beat_t   beat;
    logic         beat_valid;
    logic         advance;
    rsld_result_t result;
    rsld_run_t    out_run;

    // width register always accepts a width write
    assign cfg_ready = 1'b1;

    assign in_beat.data_byte  = data_byte;
    assign in_beat.line_start = line_start;

    rsld_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (in_beat),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    rsld_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_width (line_width),
        .fire      (advance),
        .beat      (beat),
        .result    (result)
    );

    rsld_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_run    (out_run)
    );

    // run fields to ports
    assign alpha       = out_run.alpha;
    assign color_index = out_run.color_index;
    assign transparent = out_run.transparent;
    assign run_length  = out_run.run_length;
    assign line_end    = out_run.line_end;

endmodule
